[src/ttl_aging_message_buffer_assert.svh]
// assertion macros for the ttl aging message buffer
// used by the top level only; needs a clock and an active-high reset signal
`ifndef TTL_AGING_MESSAGE_BUFFER_ASSERT_SVH
`define TTL_AGING_MESSAGE_BUFFER_ASSERT_SVH

// same-cycle implication
`define TAMB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tamb: same-cycle check failed");

// next-cycle implication
`define TAMB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tamb: next-cycle check failed");

`endif

[src/tamb_pkg.sv]
// shared types and codes for the ttl aging message buffer
// no dependencies
`default_nettype none

package tamb_pkg;

  localparam int MSG_BITS  = 32;
  localparam int TIME_BITS = 32;
  localparam int TTL_BITS  = 16;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_MSG     = 2'd0,
    STAT_ADDED   = 2'd1,
    STAT_DROPPED = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [MSG_BITS-1:0] message;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [MSG_BITS-1:0] message_out;
    logic                last;
  } out_item_t;

endpackage

`default_nettype wire

[src/tamb_ram.sv]
// single-port-write, single-port-read synchronous ram, registered read data
// no dependencies
`default_nettype none

module tamb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/tamb_seq.sv]
// sequencer: fifo pointers, tick time, expiry walk and read-out over the ram
// depends on tamb_pkg; drives one tamb_ram instance in the top level
`default_nettype none

module tamb_seq #(
  parameter int DEPTH      = 16,
  parameter int STORE_BITS = 32,
  localparam int IDX_W     = $clog2(DEPTH),
  localparam int WORD_W    = STORE_BITS + tamb_pkg::TIME_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tamb_pkg::in_item_t            in_item,
  input  wire logic [tamb_pkg::TTL_BITS-1:0] max_ttl,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output tamb_pkg::out_item_t                res_item,
  output logic                               ram_we,
  output logic      [IDX_W-1:0]              ram_waddr,
  output logic      [WORD_W-1:0]             ram_wdata,
  output logic                               ram_re,
  output logic      [IDX_W-1:0]              ram_raddr,
  input  wire logic [WORD_W-1:0]             ram_rdata
);

  import tamb_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REPLY  = 4'b0010,
    S_EXPIRE = 4'b0100,
    S_STREAM = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [IDX_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [TIME_BITS-1:0] tick_time, tick_time_next;
  logic [TIME_BITS-1:0] thresh, thresh_next;
  logic [IDX_W-1:0]     ptr, ptr_next;
  logic [CNT_W-1:0]     idx, idx_next;
  status_t              reply, reply_next;

  logic [SUM_W-1:0]      tail_sum;
  logic [IDX_W-1:0]      tail;
  logic [TIME_BITS-1:0]  ttl_ext;
  logic [TIME_BITS-1:0]  time_inc;
  logic [STORE_BITS-1:0] rd_payload;
  logic [TIME_BITS-1:0]  rd_stamp;
  logic                  stream_last;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = v + IDX_W'(1);
    end
    return r;
  endfunction

  assign tail_sum    = SUM_W'(head) + SUM_W'(count);
  assign tail        = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(tail_sum);
  assign ttl_ext     = TIME_BITS'(max_ttl);
  assign time_inc    = (tick_time == '1) ? tick_time : tick_time + TIME_BITS'(1);
  assign rd_payload  = ram_rdata[STORE_BITS-1:0];
  assign rd_stamp    = ram_rdata[STORE_BITS +: TIME_BITS];
  assign stream_last = ((idx + CNT_W'(1)) == count);
  assign ram_waddr   = tail;
  assign ram_wdata   = {tick_time, in_item.message[STORE_BITS-1:0]};

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    tick_time_next = tick_time;
    thresh_next    = thresh;
    ptr_next       = ptr;
    idx_next       = idx;
    reply_next     = reply;
    in_ready       = (state == S_IDLE);
    res_valid      = 1'b0;
    res_item       = '{status: STAT_MSG, message_out: '0, last: 1'b0};
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_item.kind)
            KIND_TICK: begin
              if (count != '0 && tick_time >= ttl_ext) begin
                ram_re      = 1'b1;
                thresh_next = tick_time - ttl_ext;
                state_next  = S_EXPIRE;
              end else begin
                tick_time_next = time_inc;
              end
            end
            KIND_ADD: begin
              if (count == CNT_W'(DEPTH)) begin
                reply_next = STAT_DROPPED;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNT_W'(1);
                reply_next = STAT_ADDED;
              end
              state_next = S_REPLY;
            end
            KIND_READ: begin
              if (count == '0) begin
                reply_next = STAT_EMPTY;
                state_next = S_REPLY;
              end else begin
                ram_re     = 1'b1;
                ptr_next   = head;
                idx_next   = '0;
                state_next = S_STREAM;
              end
            end
            KIND_CLEAR: begin
              count_next     = '0;
              head_next      = '0;
              tick_time_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_REPLY: begin
        res_valid = 1'b1;
        res_item  = '{status: reply, message_out: '0, last: 1'b1};
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_EXPIRE: begin
        // head stamp is on the ram output; stamps grow from head to tail
        if (rd_stamp < thresh) begin
          head_next  = wrap_inc(head);
          count_next = count - CNT_W'(1);
          if (count != CNT_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_inc(head);
          end else begin
            tick_time_next = time_inc;
            state_next     = S_IDLE;
          end
        end else begin
          tick_time_next = time_inc;
          state_next     = S_IDLE;
        end
      end
      S_STREAM: begin
        res_valid = 1'b1;
        res_item  = '{status: STAT_MSG, message_out: MSG_BITS'(rd_payload),
                      last: stream_last};
        if (res_ready) begin
          if (stream_last) begin
            state_next = S_IDLE;
          end else begin
            ptr_next  = wrap_inc(ptr);
            idx_next  = idx + CNT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = wrap_inc(ptr);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      tick_time <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      tick_time <= tick_time_next;
    end
  end

  always_ff @(posedge clk) begin
    thresh <= thresh_next;
    ptr    <= ptr_next;
    idx    <= idx_next;
    reply  <= reply_next;
  end

endmodule

`default_nettype wire

[src/ttl_aging_message_buffer.sv]
// add and empty read give their transaction through the reply state and the output register;
// a read of n entries streams them through the output register, one per cycle unless stalled
// a tick with nothing to expire only advances time; otherwise the one-entry-per-cycle expiry
// walk stops at a live entry or when it empties the store, then time advances; a new input is
// taken only when idle, so consumer stalls on the output also hold off the next input
// reset: rst (synchronous) empties the store, zeroes time and time-to-live; ram not cleared
`default_nettype none

`include "ttl_aging_message_buffer_assert.svh"

module ttl_aging_message_buffer #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tamb_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tamb_pkg::out_item_t                out_item,
  input  wire logic                          cfg_we,
  input  wire logic [tamb_pkg::TTL_BITS-1:0] cfg_wdata
);

  import tamb_pkg::*;

  // payload above the 32-bit message field is always zero, so never stored
  localparam int STORE_BITS = (PAYLOAD_BITS < MSG_BITS) ? PAYLOAD_BITS : MSG_BITS;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int WORD_W     = STORE_BITS + TIME_BITS;

  // time-to-live register; the user must write it only while idle, the block does not enforce this
  logic [TTL_BITS-1:0] max_ttl;

  // sequencer result path
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;

  // ram ports: each word is {stamp, payload}
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ttl <= '0;
    end else if (cfg_we) begin
      max_ttl <= cfg_wdata;
    end
  end

  tamb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tamb_seq #(
    .DEPTH      (DEPTH),
    .STORE_BITS (STORE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .max_ttl   (max_ttl),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register: frees the sequencer from the consumer's stalls
  // a new transaction loads when the register is empty or being drained
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item <= res_item;
    end
  end

  // status-only transactions always close their input
  `TAMB_ASSERT_NOW(a_status_last, clk, rst,
    out_valid && out_item.status != STAT_MSG, out_item.last)

  // message field is zero unless a stored message is out
  `TAMB_ASSERT_NOW(a_msg_zero, clk, rst,
    out_valid && out_item.status != STAT_MSG, out_item.message_out == '0)

  // a clear finishes in its acceptance cycle
  `TAMB_ASSERT_NEXT(a_clear_one_cycle, clk, rst,
    in_valid && in_ready && in_item.kind == KIND_CLEAR, in_ready)

  // the sequencer offers nothing while it waits for a new input
  `TAMB_ASSERT_NOW(a_idle_quiet, clk, rst, in_ready, !res_valid)

endmodule

`default_nettype wire
